// ----- hw/rtl/nrbp_pkg.sv -----
// shared types, constants and helpers of the node record blob parser
`default_nettype none
package nrbp_pkg;

    localparam int KEY_BYTES   = 32;
    localparam int NAME_BYTES  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PROD_W      = 42;

    localparam logic [9:0]  MS_PER_S     = 10'd1000;
    localparam logic [31:0] MAX_AGE_INIT = 32'd604800;
    localparam logic [7:0]  CHAR_LOW     = 8'h20;
    localparam logic [7:0]  CHAR_HIGH    = 8'h7E;
    localparam logic [7:0]  CHAR_SUBST   = 8'h3F;
    localparam logic [1:0]  FLAG_KEY     = 2'b01;
    localparam logic [1:0]  FLAG_LOC     = 2'b10;

    // result kinds
    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_KEY    = 3'd1;
    localparam logic [2:0] KIND_NAME   = 3'd2;
    localparam logic [2:0] KIND_END    = 3'd3;
    localparam logic [2:0] KIND_ACCEPT = 3'd4;
    localparam logic [2:0] KIND_REJECT = 3'd5;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MAGIC     = 2'd1;
    localparam logic [1:0] ERR_VERSION   = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED = 2'd3;

    // register indexes
    localparam logic [2:0] REG_MAGIC   = 3'd0;
    localparam logic [2:0] REG_VERSION = 3'd1;
    localparam logic [2:0] REG_WALL    = 3'd2;
    localparam logic [2:0] REG_UPTIME  = 3'd3;
    localparam logic [2:0] REG_MAX_AGE = 3'd4;

    // emit mask bits, in result order
    localparam int EM_KEY    = 0;
    localparam int EM_NAME   = 1;
    localparam int EM_HDR    = 2;
    localparam int EM_HEX_HI = 3;
    localparam int EM_HEX_LO = 4;
    localparam int EM_END    = 5;
    localparam int EM_ACCEPT = 6;
    localparam int EM_REJECT = 7;

    // results caused by one input byte
    typedef struct packed {
        logic [7:0]  emit;
        logic [7:0]  data;
        logic [1:0]  err;
        logic [7:0]  hash;
        logic [7:0]  role;
        logic [1:0]  flags;
        logic [31:0] advert;
        logic [31:0] diff;
        logic        rebase_ok;
        logic [31:0] lat;
        logic [31:0] lon;
    } job_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = 8'h30 + {4'd0, nib};
        else
            c = 8'h37 + {4'd0, nib};
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/nrbp_front.sv -----
// front part: byte parsing and classification into result jobs
`default_nettype none
module nrbp_front
    import nrbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        take,
    input  wire logic [7:0]  blob_byte,
    input  wire logic        first_byte,
    input  wire logic        final_byte,
    input  wire logic [31:0] format_magic,
    input  wire logic [15:0] format_version,
    input  wire logic [31:0] wall_clock_seconds,
    input  wire logic [31:0] max_age_seconds,
    output logic             push,
    output job_t             job
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_MAGIC, PH_VERSION, PH_COUNT, PH_FIXED, PH_KEY, PH_LOC, PH_NAME
    } phase_t;

    phase_t      phase_reg, phase_next, phase_eff;
    logic [7:0]  cnt_reg, cnt_next, cnt_eff, cnt_inc;
    logic [15:0] left_reg, left_next, left_dec;
    logic [31:0] word_reg, word_next, shifted;
    logic [7:0]  hash_reg, hash_next, role_reg, role_next, nlen_reg, nlen_next;
    logic [1:0]  flags_reg, flags_next;
    logic [31:0] advert_reg, advert_next, diff_reg, diff_next;
    logic [31:0] lat_reg, lat_next, lon_reg, lon_next;
    logic        ok_reg, ok_next, keep_reg, keep_next;
    logic        do_head, do_end;
    logic [7:0]  emit;
    logic [1:0]  err;
    logic [7:0]  data;

    // next-state and job classification for one byte
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        left_next   = left_reg;
        word_next   = word_reg;
        hash_next   = hash_reg;
        role_next   = role_reg;
        nlen_next   = nlen_reg;
        flags_next  = flags_reg;
        advert_next = advert_reg;
        diff_next   = diff_reg;
        ok_next     = ok_reg;
        lat_next    = lat_reg;
        lon_next    = lon_reg;
        keep_next   = keep_reg;
        do_head     = 1'b0;
        do_end      = 1'b0;
        emit        = '0;
        err         = ERR_NONE;
        data        = blob_byte;
        left_dec    = '0;

        phase_eff = first_byte ? PH_MAGIC : phase_reg;
        cnt_eff   = first_byte ? 8'd0 : cnt_reg;
        shifted   = first_byte ? {blob_byte, 24'd0} : {blob_byte, word_reg[31:8]};
        cnt_inc   = cnt_eff + 8'd1;
        if (first_byte)
        begin
            left_next = '0;
            word_next = '0;
        end

        case (phase_eff)
            PH_MAGIC:
            begin
                word_next = shifted;
                cnt_next  = cnt_inc;
                if (cnt_inc == 8'd4)
                begin
                    if (shifted != format_magic)
                    begin
                        emit[EM_REJECT] = 1'b1;
                        err             = ERR_MAGIC;
                        phase_next      = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_VERSION;
                        cnt_next   = '0;
                    end
                end
                else
                    phase_next = PH_MAGIC;
            end
            PH_VERSION:
            begin
                word_next = shifted;
                cnt_next  = cnt_inc;
                if (cnt_inc == 8'd2)
                begin
                    if (shifted[31:16] != format_version)
                    begin
                        emit[EM_REJECT] = 1'b1;
                        err             = ERR_VERSION;
                        phase_next      = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_COUNT;
                        cnt_next   = '0;
                    end
                end
            end
            PH_COUNT:
            begin
                word_next = shifted;
                cnt_next  = cnt_inc;
                if (cnt_inc == 8'd2)
                begin
                    left_next = shifted[31:16];
                    if (shifted[31:16] == 16'd0)
                    begin
                        emit[EM_ACCEPT] = 1'b1;
                        phase_next      = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_FIXED;
                        cnt_next   = '0;
                    end
                end
            end
            PH_FIXED:
            begin
                if (cnt_eff == 8'd0)
                begin
                    hash_next = blob_byte;
                    lat_next  = '0;
                    lon_next  = '0;
                end
                else if (cnt_eff == 8'd1)
                    role_next = blob_byte;
                else if (cnt_eff == 8'd2)
                    flags_next = blob_byte[1:0];
                else if (cnt_eff == 8'd3)
                    nlen_next = blob_byte;
                else
                    word_next = shifted;
                cnt_next = cnt_inc;
                if (cnt_inc == 8'd8)
                    advert_next = shifted;
                if (cnt_inc == 8'd12)
                begin
                    diff_next = wall_clock_seconds - shifted;
                    ok_next   = (wall_clock_seconds != 32'd0) && (shifted != 32'd0)
                                && (shifted <= wall_clock_seconds);
                    keep_next = !((wall_clock_seconds != 32'd0) && (shifted != 32'd0)
                                && (wall_clock_seconds > shifted)
                                && ((wall_clock_seconds - shifted) > max_age_seconds));
                    cnt_next  = '0;
                    if ((flags_reg & FLAG_KEY) != 2'd0)
                        phase_next = PH_KEY;
                    else if ((flags_reg & FLAG_LOC) != 2'd0)
                        phase_next = PH_LOC;
                    else
                        do_head = 1'b1;
                end
            end
            PH_KEY:
            begin
                emit[EM_KEY] = keep_reg;
                cnt_next     = cnt_inc;
                if (cnt_inc >= 8'(KEY_BYTES))
                begin
                    cnt_next = '0;
                    if ((flags_reg & FLAG_LOC) != 2'd0)
                        phase_next = PH_LOC;
                    else
                        do_head = 1'b1;
                end
            end
            PH_LOC:
            begin
                word_next = shifted;
                cnt_next  = cnt_inc;
                if (cnt_inc == 8'd4)
                    lat_next = shifted;
                if (cnt_inc == 8'd8)
                begin
                    lon_next = shifted;
                    do_head  = 1'b1;
                end
            end
            PH_NAME:
            begin
                if (keep_reg && (cnt_eff < 8'(NAME_BYTES)))
                    emit[EM_NAME] = 1'b1;
                if ((blob_byte < CHAR_LOW) || (blob_byte > CHAR_HIGH))
                    data = CHAR_SUBST;
                cnt_next = cnt_inc;
                if (cnt_inc >= nlen_reg)
                    do_end = 1'b1;
            end
            default:
            begin
            end
        endcase

        // header done: header, stand-in name or name phase
        if (do_head)
        begin
            emit[EM_HDR] = keep_next;
            if (nlen_next == 8'd0)
            begin
                emit[EM_HEX_HI] = keep_next;
                emit[EM_HEX_LO] = keep_next;
                do_end          = 1'b1;
            end
            else
            begin
                phase_next = PH_NAME;
                cnt_next   = '0;
            end
        end

        // record end: next record or blob accepted
        if (do_end)
        begin
            left_dec  = left_next - 16'd1;
            left_next = left_dec;
            if (left_dec == 16'd0)
            begin
                emit[EM_ACCEPT] = 1'b1;
                phase_next      = PH_IDLE;
            end
            else
            begin
                emit[EM_END] = keep_next;
                phase_next   = PH_FIXED;
                cnt_next     = '0;
            end
        end

        // early end of blob
        if (final_byte && (phase_next != PH_IDLE))
        begin
            emit[EM_REJECT] = 1'b1;
            err             = ERR_TRUNCATED;
            phase_next      = PH_IDLE;
        end
    end

    // job snapshot
    always_comb
    begin
        job.emit      = emit;
        job.data      = data;
        job.err       = err;
        job.hash      = hash_next;
        job.role      = role_next;
        job.flags     = flags_next;
        job.advert    = advert_next;
        job.diff      = diff_next;
        job.rebase_ok = ok_next;
        job.lat       = lat_next;
        job.lon       = lon_next;
        push          = take && (emit != 8'd0);
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            cnt_reg    <= '0;
            left_reg   <= '0;
            word_reg   <= '0;
            hash_reg   <= '0;
            role_reg   <= '0;
            nlen_reg   <= '0;
            flags_reg  <= '0;
            advert_reg <= '0;
            diff_reg   <= '0;
            ok_reg     <= 1'b0;
            lat_reg    <= '0;
            lon_reg    <= '0;
            keep_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            left_reg   <= left_next;
            word_reg   <= word_next;
            hash_reg   <= hash_next;
            role_reg   <= role_next;
            nlen_reg   <= nlen_next;
            flags_reg  <= flags_next;
            advert_reg <= advert_next;
            diff_reg   <= diff_next;
            ok_reg     <= ok_next;
            lat_reg    <= lat_next;
            lon_reg    <= lon_next;
            keep_reg   <= keep_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/nrbp_queue.sv -----
// short job queue between front and back
`default_nettype none
module nrbp_queue
    import nrbp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_job,
    input  wire logic pop,
    output logic      head_valid,
    output job_t      head_job,
    output logic      full
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_job   = mem[rd_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_job;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + QPTR_W'(1);
            if (pop)
                rd_reg <= rd_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/nrbp_back.sv -----
// back part: expands jobs into result transfers, rebases last-seen
`default_nettype none
module nrbp_back
    import nrbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  job_t             head_job,
    output logic             pop,
    input  wire logic [31:0] uptime_millis,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [7:0]       path_hash,
    output logic [7:0]       node_role,
    output logic             has_key,
    output logic             has_location,
    output logic [31:0]      advert_time,
    output logic [31:0]      last_seen_ms,
    output logic [31:0]      latitude_bits,
    output logic [31:0]      longitude_bits,
    output logic [7:0]       payload_byte,
    output logic [1:0]       error_code,
    output logic             last_of_run
);

    job_t              cur_reg;
    logic [7:0]        mask_reg, mask_next, pick;
    logic [PROD_W-1:0] prod_reg;
    logic              adv, emitting;
    logic [31:0]       seen_ms;

    logic              ov_reg;
    logic [2:0]        kind_reg;
    logic [7:0]        hash_reg, role_reg, pay_reg;
    logic              hk_reg, hl_reg, last_reg;
    logic [31:0]       adv_reg, seen_reg, lat_reg, lon_reg;
    logic [1:0]        err_reg;

    assign adv      = !ov_reg || !out_stall;
    assign emitting = adv && (mask_reg != 8'd0);
    assign pick     = mask_reg & (~mask_reg + 8'd1);
    assign mask_next = mask_reg & ~pick;
    assign pop      = head_valid && ((mask_reg == 8'd0) || (emitting && (mask_next == 8'd0)));

    // rebased last-seen from the registered product
    always_comb
    begin
        if (!cur_reg.rebase_ok || (prod_reg > {10'd0, uptime_millis}))
            seen_ms = '0;
        else
            seen_ms = uptime_millis - prod_reg[31:0];
    end

    // current job and age product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            cur_reg  <= '0;
            prod_reg <= '0;
        end
        else if (pop)
        begin
            cur_reg  <= head_job;
            mask_reg <= head_job.emit;
            prod_reg <= {10'd0, head_job.diff} * {32'd0, MS_PER_S};
        end
        else if (emitting)
            mask_reg <= mask_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg   <= 1'b0;
            kind_reg <= '0;
            hash_reg <= '0;
            role_reg <= '0;
            pay_reg  <= '0;
            hk_reg   <= 1'b0;
            hl_reg   <= 1'b0;
            last_reg <= 1'b0;
            adv_reg  <= '0;
            seen_reg <= '0;
            lat_reg  <= '0;
            lon_reg  <= '0;
            err_reg  <= '0;
        end
        else if (adv)
        begin
            ov_reg   <= (mask_reg != 8'd0);
            hash_reg <= '0;
            role_reg <= '0;
            pay_reg  <= '0;
            hk_reg   <= 1'b0;
            hl_reg   <= 1'b0;
            adv_reg  <= '0;
            seen_reg <= '0;
            lat_reg  <= '0;
            lon_reg  <= '0;
            err_reg  <= ERR_NONE;
            kind_reg <= KIND_HEADER;
            last_reg <= (mask_next == 8'd0);
            case (pick)
                8'(1 << EM_KEY):
                begin
                    kind_reg <= KIND_KEY;
                    pay_reg  <= cur_reg.data;
                end
                8'(1 << EM_NAME):
                begin
                    kind_reg <= KIND_NAME;
                    pay_reg  <= cur_reg.data;
                end
                8'(1 << EM_HDR):
                begin
                    kind_reg <= KIND_HEADER;
                    hash_reg <= cur_reg.hash;
                    role_reg <= cur_reg.role;
                    hk_reg   <= cur_reg.flags[0];
                    hl_reg   <= cur_reg.flags[1];
                    adv_reg  <= cur_reg.advert;
                    seen_reg <= seen_ms;
                    lat_reg  <= cur_reg.lat;
                    lon_reg  <= cur_reg.lon;
                end
                8'(1 << EM_HEX_HI):
                begin
                    kind_reg <= KIND_NAME;
                    pay_reg  <= hex_char(cur_reg.hash[7:4]);
                end
                8'(1 << EM_HEX_LO):
                begin
                    kind_reg <= KIND_NAME;
                    pay_reg  <= hex_char(cur_reg.hash[3:0]);
                end
                8'(1 << EM_END):
                    kind_reg <= KIND_END;
                8'(1 << EM_ACCEPT):
                    kind_reg <= KIND_ACCEPT;
                8'(1 << EM_REJECT):
                begin
                    kind_reg <= KIND_REJECT;
                    err_reg  <= cur_reg.err;
                end
                default:
                    kind_reg <= KIND_HEADER;
            endcase
        end
    end

    assign out_valid      = ov_reg;
    assign kind           = kind_reg;
    assign path_hash      = hash_reg;
    assign node_role      = role_reg;
    assign has_key        = hk_reg;
    assign has_location   = hl_reg;
    assign advert_time    = adv_reg;
    assign last_seen_ms   = seen_reg;
    assign latitude_bits  = lat_reg;
    assign longitude_bits = lon_reg;
    assign payload_byte   = pay_reg;
    assign error_code     = err_reg;
    assign last_of_run    = last_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/node_record_blob_parser.sv -----
// node record blob parser: one blob byte per transfer in, parsed results out
// throughput: one input byte per cycle while the job queue has room; one result per cycle unless out_stall
// a byte causes at most six results, which leave the result side one after another
// path: a byte's job passes the job queue and the current-job register, then each result the output register
// reset: parser waits for a first byte, queue and output empty, registers cleared,
// age limit returns to one week
`default_nettype none
module node_record_blob_parser
    import nrbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  blob_byte,
    input  wire logic        first_byte,
    input  wire logic        final_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [7:0]       path_hash,
    output logic [7:0]       node_role,
    output logic             has_key,
    output logic             has_location,
    output logic [31:0]      advert_time,
    output logic [31:0]      last_seen_ms,
    output logic [31:0]      latitude_bits,
    output logic [31:0]      longitude_bits,
    output logic [7:0]       payload_byte,
    output logic [1:0]       error_code,
    output logic             last_of_run,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [31:0] magic_reg, wall_reg, uptime_reg, max_age_reg;
    logic [15:0] version_reg;
    logic        take, push, pop, head_valid, full;
    job_t        push_job, head_job;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= '0;
            version_reg <= '0;
            wall_reg    <= '0;
            uptime_reg  <= '0;
            max_age_reg <= MAX_AGE_INIT;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[4:2])
                REG_MAGIC:   magic_reg   <= pwdata;
                REG_VERSION: version_reg <= pwdata[15:0];
                REG_WALL:    wall_reg    <= pwdata;
                REG_UPTIME:  uptime_reg  <= pwdata;
                REG_MAX_AGE: max_age_reg <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[4:2])
            REG_MAGIC:   prdata = magic_reg;
            REG_VERSION: prdata = {16'd0, version_reg};
            REG_WALL:    prdata = wall_reg;
            REG_UPTIME:  prdata = uptime_reg;
            REG_MAX_AGE: prdata = max_age_reg;
            default:     prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign in_stall = full;
    assign take     = in_valid && !full;

    nrbp_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .take               (take),
        .blob_byte          (blob_byte),
        .first_byte         (first_byte),
        .final_byte         (final_byte),
        .format_magic       (magic_reg),
        .format_version     (version_reg),
        .wall_clock_seconds (wall_reg),
        .max_age_seconds    (max_age_reg),
        .push               (push),
        .job                (push_job)
    );

    nrbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .full       (full)
    );

    nrbp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_job       (head_job),
        .pop            (pop),
        .uptime_millis  (uptime_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .path_hash      (path_hash),
        .node_role      (node_role),
        .has_key        (has_key),
        .has_location   (has_location),
        .advert_time    (advert_time),
        .last_seen_ms   (last_seen_ms),
        .latitude_bits  (latitude_bits),
        .longitude_bits (longitude_bits),
        .payload_byte   (payload_byte),
        .error_code     (error_code),
        .last_of_run    (last_of_run)
    );

endmodule
`default_nettype wire
